/* design/tpp_pkg.sv */
// ----------------------------------------------------------------------------
// tpp_pkg
// shared types and constants of the tlv parameter parser
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TYPE_W  = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SIZE_W  = 8;
    localparam int unsigned POS_W   = 2;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [1:0] CODE_CUSTOM = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_VALUE  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [TYPE_W-1:0]  param_type;
        logic [VALUE_W-1:0] param_value;
        logic [SIZE_W-1:0]  param_size;
        logic               custom_size;
        logic               truncated;
        logic               last_param;
    } t_result;

endpackage

/* design/tpp_in_reg.sv */
// ----------------------------------------------------------------------------
// tpp_in_reg
// input register stage, holds one byte word until the parser takes it
// ----------------------------------------------------------------------------
module tpp_in_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tvalid,
    output logic                       o_tready,
    input  logic [tpp_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    input  logic                       i_advance,
    output logic                       o_valid,
    output logic [tpp_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_last
);
    import tpp_pkg::*;

    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    logic               n_valid;
    logic               w_load;

    assign o_tready = !r_valid || i_advance;
    assign w_load   = i_tvalid && o_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

/* design/tpp_parse.sv */
// ----------------------------------------------------------------------------
// tpp_parse
// parser state and per-byte update, flags a finished or cut-off parameter
// ----------------------------------------------------------------------------
module tpp_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [tpp_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output logic                       o_emit,
    output tpp_pkg::t_result           o_result
);
    import tpp_pkg::*;

    t_phase             r_phase;
    logic [SIZE_W-1:0]  r_left;
    logic [TYPE_W-1:0]  r_type;
    logic [VALUE_W-1:0] r_value;
    logic [SIZE_W-1:0]  r_size;
    logic [POS_W-1:0]   r_pos;

    t_phase             n_phase;
    logic [SIZE_W-1:0]  n_left;
    logic [TYPE_W-1:0]  n_type;
    logic [VALUE_W-1:0] n_value;
    logic [SIZE_W-1:0]  n_size;
    logic [POS_W-1:0]   n_pos;

    logic               w_custom;
    logic               w_trunc;
    logic               w_lastp;
    logic [1:0]         w_code;
    logic [VALUE_W-1:0] w_shifted;
    logic [SIZE_W-1:0]  w_dec;

    assign w_code = i_byte[7:6];
    assign w_dec  = r_left - SIZE_W'(1);

    always_comb begin
        case (r_pos)
            2'd0:    w_shifted = {24'd0, i_byte};
            2'd1:    w_shifted = {16'd0, i_byte, 8'd0};
            2'd2:    w_shifted = {8'd0, i_byte, 16'd0};
            default: w_shifted = {i_byte, 24'd0};
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_type   = r_type;
        n_value  = r_value;
        n_size   = r_size;
        n_pos    = r_pos;
        o_emit   = 1'b0;
        w_custom = 1'b0;
        w_trunc  = 1'b0;
        w_lastp  = i_last;
        case (r_phase)
            PH_HEADER: begin
                n_type  = i_byte[5:0];
                n_value = '0;
                n_pos   = '0;
                if (w_code == CODE_CUSTOM) begin
                    n_size   = '0;
                    n_left   = '0;
                    n_phase  = PH_LENGTH;
                    w_custom = 1'b1;
                end else begin
                    n_size  = SIZE_W'(1) << w_code;
                    n_left  = SIZE_W'(1) << w_code;
                    n_phase = PH_VALUE;
                end
                o_emit  = i_last;
                w_trunc = 1'b1;
            end
            PH_VALUE: begin
                n_value = r_value | w_shifted;
                n_pos   = r_pos + POS_W'(1);
                n_left  = w_dec;
                if (w_dec == '0) begin
                    o_emit  = 1'b1;
                    n_phase = PH_HEADER;
                end else begin
                    o_emit  = i_last;
                    w_trunc = 1'b1;
                end
            end
            PH_LENGTH: begin
                w_custom = 1'b1;
                n_size   = i_byte;
                n_left   = i_byte;
                if (i_byte == '0) begin
                    o_emit  = 1'b1;
                    n_phase = PH_HEADER;
                end else begin
                    n_phase = PH_SKIP;
                    o_emit  = i_last;
                    w_trunc = 1'b1;
                end
            end
            default: begin
                w_custom = 1'b1;
                n_left   = w_dec;
                if (w_dec == '0) begin
                    o_emit  = 1'b1;
                    n_phase = PH_HEADER;
                end else begin
                    o_emit  = i_last;
                    w_trunc = 1'b1;
                end
            end
        endcase
        if (i_last) begin
            n_phase = PH_HEADER;
        end
    end

    always_comb begin
        o_result.param_type  = n_type;
        o_result.param_value = w_custom ? '0 : n_value;
        o_result.param_size  = n_size;
        o_result.custom_size = w_custom;
        o_result.truncated   = w_trunc;
        o_result.last_param  = w_lastp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_left  <= '0;
            r_type  <= '0;
            r_value <= '0;
            r_size  <= '0;
            r_pos   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_type  <= n_type;
            r_value <= n_value;
            r_size  <= n_size;
            r_pos   <= n_pos;
        end
    end

endmodule

/* design/tpp_out_reg.sv */
// ----------------------------------------------------------------------------
// tpp_out_reg
// result register, holds one parameter word until the sink takes it
// ----------------------------------------------------------------------------
module tpp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tpp_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_tready,
    output tpp_pkg::t_result o_result
);
    import tpp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/tlv_parameter_parser_unit.sv */
// ----------------------------------------------------------------------------
// tlv_parameter_parser_unit
// path: the byte that completes a parameter passes the input register, then the
// parser update, then the result register; throughput: one byte word per cycle
// while the result register is free or the byte completes no parameter
// reset: synchronous active-low, empties both registers and returns the
// parser to header expected
// ----------------------------------------------------------------------------
module tlv_parameter_parser_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tpp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // data_byte
    input  logic                                 s_axis_tlast,  // last_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // param_type [5:0], param_value [37:6], param_size [45:38], zero pad
    output logic [tpp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // custom_size [0], truncated [1]
    output logic [tpp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast   // last_param
);
    import tpp_pkg::*;

    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_in_last;
    logic              w_emit;
    logic              w_free;
    logic              w_advance;
    t_result           w_result;
    t_result           w_out;

    assign w_advance = w_in_valid && (!w_emit || w_free);

    tpp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte),
        .o_last    (w_in_last)
    );

    tpp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (w_in_byte),
        .i_last    (w_in_last),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    tpp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_emit),
        .i_result (w_result),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_result (w_out)
    );

    assign m_axis_tdata = {2'b00, w_out.param_size, w_out.param_value, w_out.param_type};
    assign m_axis_tuser = {w_out.truncated, w_out.custom_size};
    assign m_axis_tlast = w_out.last_param;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for tlv_parameter_parser_unit: byte words are sent in
// random bursts as well-formed parameter regions, cut regions and noise, a
// parser model predicts every result word, and the output stream is compared
// field by field under random and long receiver stalls
// ----------------------------------------------------------------------------
module tb;
    import tpp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1850;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_AT      = 700;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // data_byte
    logic                   s_axis_tlast = 1'b0; // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // param_type [5:0], param_value [37:6], param_size [45:38], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // custom_size [0], truncated [1]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;        // last_param

    t_byte_word  pending_bytes[$];
    t_result     expected_params[$];
    int unsigned total_bytes;
    int unsigned bytes_offered = 0;
    int unsigned bytes_accepted = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stall_mode = 0;
    int unsigned stall_mode_left = 0;

    // parser model state
    t_phase             prs_phase = PH_HEADER;
    logic [SIZE_W-1:0]  prs_left = '0;
    logic [TYPE_W-1:0]  prs_type = '0;
    logic [VALUE_W-1:0] prs_value = '0;
    logic [SIZE_W-1:0]  prs_size = '0;
    logic [POS_W-1:0]   prs_pos = '0;

    tlv_parameter_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result param_word(input bit custom, input bit trunc, input bit lst);
        t_result r;
        r.param_type  = prs_type;
        r.param_value = custom ? '0 : prs_value;
        r.param_size  = prs_size;
        r.custom_size = custom;
        r.truncated   = trunc;
        r.last_param  = lst;
        return r;
    endfunction

    // advances the parser model by one byte, returns 1 when a parameter word is due
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic lst,
                                      output t_result r);
        logic [1:0] code;
        bit         hit;
        hit  = 1'b0;
        r    = '0;
        code = b[7:6];
        case (prs_phase)
            PH_HEADER: begin
                prs_type  = b[TYPE_W-1:0];
                prs_value = '0;
                prs_pos   = '0;
                if (code == CODE_CUSTOM) begin
                    prs_size  = '0;
                    prs_left  = '0;
                    prs_phase = PH_LENGTH;
                end else begin
                    prs_size  = 8'd1 << code;
                    prs_left  = prs_size;
                    prs_phase = PH_VALUE;
                end
                if (lst) begin
                    hit = 1'b1;
                    r   = param_word(code == CODE_CUSTOM, 1'b1, 1'b1);
                end
            end
            PH_VALUE: begin
                prs_value = prs_value | (VALUE_W'(b) << (8 * prs_pos));
                prs_pos   = prs_pos + 1'b1;
                prs_left  = prs_left - 1'b1;
                if (prs_left == 0) begin
                    hit       = 1'b1;
                    r         = param_word(1'b0, 1'b0, lst);
                    prs_phase = PH_HEADER;
                end else if (lst) begin
                    hit = 1'b1;
                    r   = param_word(1'b0, 1'b1, 1'b1);
                end
            end
            PH_LENGTH: begin
                prs_size = b;
                prs_left = b;
                if (b == 0) begin
                    hit       = 1'b1;
                    r         = param_word(1'b1, 1'b0, lst);
                    prs_phase = PH_HEADER;
                end else begin
                    prs_phase = PH_SKIP;
                    if (lst) begin
                        hit = 1'b1;
                        r   = param_word(1'b1, 1'b1, 1'b1);
                    end
                end
            end
            default: begin
                prs_left = prs_left - 1'b1;
                if (prs_left == 0) begin
                    hit       = 1'b1;
                    r         = param_word(1'b1, 1'b0, lst);
                    prs_phase = PH_HEADER;
                end else if (lst) begin
                    hit = 1'b1;
                    r   = param_word(1'b1, 1'b1, 1'b1);
                end
            end
        endcase
        if (lst) begin
            prs_phase = PH_HEADER;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
        t_byte_word w;
        w.data = b;
        w.last = lst;
        pending_bytes = {pending_bytes, w};
    endtask

    // one region of whole parameters, sometimes cut short or left open
    task automatic push_region();
        logic [BYTE_W-1:0] seg[$];
        logic [BYTE_W-1:0] hdr;
        int unsigned       n_params;
        int unsigned       len;
        int unsigned       keep;
        bit                mark_last;
        n_params  = $urandom_range(1, 6);
        mark_last = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < n_params; k++) begin
            hdr = 8'($urandom);
            seg = {seg, hdr};
            if (hdr[7:6] == CODE_CUSTOM) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 6);
                seg = {seg, 8'(len)};
                repeat (len) seg = {seg, 8'($urandom)};
            end else begin
                repeat (1 << hdr[7:6]) seg = {seg, 8'($urandom)};
            end
        end
        keep = seg.size();
        if (keep > 1 && $urandom_range(0, 3) == 0) begin
            keep = $urandom_range(1, seg.size() - 1);
        end
        for (int i = 0; i < keep; i++) begin
            push_byte(seg[i], mark_last && (i == keep - 1));
        end
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom), ($urandom_range(0, 3) == 0));
    endtask

    // stimulus and end of run
    initial begin
        // one byte value, smallest
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        // two byte value, all ones
        push_byte(8'h7f, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0);
        // four byte value completed on the last byte
        push_byte(8'hbf, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h80, 1'b1);
        // custom size of zero
        push_byte(8'hc5, 1'b0);
        push_byte(8'h00, 1'b0);
        // custom size completed on the last byte
        push_byte(8'hc1, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h55, 1'b1);
        // custom header as the last byte
        push_byte(8'hff, 1'b1);
        // region ends inside a value
        push_byte(8'h82, 1'b0);
        push_byte(8'h55, 1'b1);
        // region ends on the length byte
        push_byte(8'hc3, 1'b0);
        push_byte(8'h03, 1'b1);
        // region ends on a value header
        push_byte(8'h00, 1'b1);
        while (pending_bytes.size() < RANDOM_BYTES + 22) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
            end else begin
                push_region();
            end
        end
        total_bytes = pending_bytes.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (bytes_accepted != total_bytes || expected_params.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // result check first, then prediction of the byte word taken at this edge
    always @(posedge i_clk) begin : check_and_predict
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_params.size() == 0) begin
                    report_mismatch("unexpected result word", m_axis_tdata[37:6], '0);
                end else begin
                    want = expected_params.pop_front();
                    if (m_axis_tdata[5:0] !== want.param_type)
                        report_mismatch("param_type", m_axis_tdata[5:0], want.param_type);
                    if (m_axis_tdata[37:6] !== want.param_value)
                        report_mismatch("param_value", m_axis_tdata[37:6], want.param_value);
                    if (m_axis_tdata[45:38] !== want.param_size)
                        report_mismatch("param_size", m_axis_tdata[45:38], want.param_size);
                    if (m_axis_tdata[47:46] !== 2'b00)
                        report_mismatch("tdata padding", m_axis_tdata[47:46], '0);
                    if (m_axis_tuser[0] !== want.custom_size)
                        report_mismatch("custom_size", m_axis_tuser[0], want.custom_size);
                    if (m_axis_tuser[1] !== want.truncated)
                        report_mismatch("truncated", m_axis_tuser[1], want.truncated);
                    if (m_axis_tlast !== want.last_param)
                        report_mismatch("last_param", m_axis_tlast, want.last_param);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_accepted++;
                if (parse_byte(s_axis_tdata, s_axis_tlast, got)) begin
                    expected_params = {expected_params, got};
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin : drive_bytes
        t_byte_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || bytes_accepted == bytes_offered) begin
            if (gap_left > 0 && hold_left == 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                w = pending_bytes.pop_front();
                s_axis_tdata  <= w.data;
                s_axis_tlast  <= w.last;
                s_axis_tvalid <= 1'b1;
                bytes_offered++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern of its own plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && bytes_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (stall_mode_left == 0) begin
                    stall_mode      = $urandom_range(0, 3);
                    stall_mode_left = $urandom_range(20, 200);
                end
                stall_mode_left--;
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

endmodule

/* files.f */
design/tpp_pkg.sv
design/tpp_in_reg.sv
design/tpp_parse.sv
design/tpp_out_reg.sv
design/tlv_parameter_parser_unit.sv
sim/tb.sv
